// File: design/tlb_pkg.sv
// Package: types, constants and command codes for the clock-replacement TLB.
package tlb_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 21;
    localparam int FIELD_BITS      = 21;
    localparam int CNT_BITS        = 5;
    localparam logic [CNT_BITS-1:0] CNT_RESET = 5'd16;
    localparam int MAX_ACTIVE      = 16;

    typedef enum logic [2:0] {
        FN_LOOKUP    = 3'd0,
        FN_INSERT    = 3'd1,
        FN_CLR_ENTRY = 3'd2,
        FN_CLR_ALL   = 3'd3,
        FN_CLR_REF   = 3'd4,
        FN_WRITEBACK = 3'd5,
        FN_RSVD6     = 3'd6,
        FN_RSVD7     = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0]            func;
        logic [FIELD_BITS-1:0] virt_page;
        logic                  is_store;
        logic [FIELD_BITS-1:0] new_frame;
        logic                  new_ref;
        logic                  new_mod;
    } t_in_word;

    typedef struct packed {
        logic                  hit;
        logic [FIELD_BITS-1:0] frame;
        logic                  wb_valid;
        logic [FIELD_BITS-1:0] wb_frame;
        logic                  wb_mod;
        logic                  wb_ref;
        logic                  last;
    } t_out_word;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input word, start command
        logic exec;      // apply the command (lookup/clear/insert commit)
        logic scan;      // step the scan index (insert search / write-back walk)
        logic emit;      // load output register from current command
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        t_func func;
        logic  found;     // insert: scan index is a candidate
        logic  scan_end;  // insert: every active entry examined, index back at start
        logic  wb_hit;    // write-back: scan index is a valid entry
        logic  wb_more;   // write-back: another valid entry follows
    } t_status;

endpackage

// File: design/tlb_ctrl.sv
// Controller: sequences each command over the datapath.
module tlb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  tlb_pkg::t_status  i_status,
    output tlb_pkg::t_cmd     o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_DECODE, S_SCAN, S_HOLD} t_state;
    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_stall  = (r_state != S_IDLE);

    // command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        unique case (r_state)
            S_DECODE: begin
                unique case (i_status.func)
                    tlb_pkg::FN_LOOKUP: begin
                        o_cmd.exec = out_free;
                        o_cmd.emit = out_free;
                    end
                    tlb_pkg::FN_INSERT,
                    tlb_pkg::FN_WRITEBACK: o_cmd.scan = 1'b0;
                    default: o_cmd.exec = 1'b1;
                endcase
            end
            S_SCAN: begin
                if (i_status.func == tlb_pkg::FN_INSERT) begin
                    if ((i_status.found || i_status.scan_end) && out_free) begin
                        o_cmd.exec = 1'b1;
                        o_cmd.emit = 1'b1;
                    end else if (!(i_status.found || i_status.scan_end)) begin
                        o_cmd.scan = 1'b1;
                    end
                end else begin
                    if (i_status.wb_hit) begin
                        o_cmd.emit = out_free;
                        o_cmd.scan = out_free;
                    end else begin
                        o_cmd.scan = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    unique case (i_status.func)
                        tlb_pkg::FN_LOOKUP: if (out_free) r_state <= S_IDLE;
                        tlb_pkg::FN_INSERT,
                        tlb_pkg::FN_WRITEBACK: r_state <= S_SCAN;
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SCAN: begin
                    if (i_status.func == tlb_pkg::FN_INSERT) begin
                        if (o_cmd.exec) r_state <= S_IDLE;
                    end else if (i_status.wb_hit) begin
                        if (out_free && !i_status.wb_more) r_state <= S_IDLE;
                    end else if (!i_status.wb_more) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/tlb_datapath.sv
// Datapath: entry storage, match logic, clock hand and output register.
module tlb_datapath #(
    parameter int NUM_ENTRIES = tlb_pkg::NUM_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlb_pkg::t_in_word             i_word,
    input  logic                          i_cfg_we,
    input  logic [tlb_pkg::CNT_BITS-1:0]  i_cfg_data,
    input  tlb_pkg::t_cmd                 i_cmd,
    output tlb_pkg::t_status              o_status,
    output tlb_pkg::t_out_word            o_word
);
    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int NW = $clog2(NUM_ENTRIES + 1);
    localparam int FB = tlb_pkg::FIELD_BITS;
    localparam int PAGE_BITS = tlb_pkg::PAGE_BITS_DEF;

    logic [NUM_ENTRIES-1:0] r_valid, r_ref, r_mod;
    logic [PAGE_BITS-1:0]   r_page  [NUM_ENTRIES];
    logic [FB-1:0]          r_frame [NUM_ENTRIES];
    logic [IW-1:0]          r_hand, r_idx;
    logic [NW-1:0]          r_steps;
    logic [tlb_pkg::CNT_BITS-1:0] r_cfg;
    tlb_pkg::t_in_word      r_in;
    tlb_pkg::t_out_word     r_out;
    tlb_pkg::t_out_word     n_out;

    logic [NW-1:0]          n_act;
    logic [NUM_ENTRIES-1:0] active, match, page_eq;
    logic [IW-1:0]          hit_idx, next_idx;
    logic                   any_hit;
    logic [PAGE_BITS-1:0]   in_page;
    logic                   wb_more;

    assign in_page = PAGE_BITS'(r_in.virt_page);

    // active count: clamp to 1..min(16, depth)
    always_comb begin
        int lim;
        lim = (tlb_pkg::MAX_ACTIVE < NUM_ENTRIES) ? tlb_pkg::MAX_ACTIVE : NUM_ENTRIES;
        if (r_cfg == '0) n_act = NW'(1);
        else if (int'(r_cfg) > lim) n_act = NW'(lim);
        else n_act = NW'(r_cfg);
    end

    // per-entry match, lowest index wins
    always_comb begin
        hit_idx = '0;
        any_hit = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            active[i]  = (i < int'(n_act));
            page_eq[i] = (r_page[i] == in_page);
            match[i]   = active[i] && r_valid[i] && page_eq[i];
        end
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = IW'(i);
                any_hit = 1'b1;
            end
        end
    end

    // further valid entry after the scan index (write-back)
    always_comb begin
        wb_more = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (active[i] && r_valid[i] && IW'(i) > r_idx) wb_more = 1'b1;
    end

    assign next_idx = ({1'b0, r_idx} + 1'b1 >= (IW+1)'(n_act)) ? '0 : r_idx + 1'b1;

    assign o_status.func     = tlb_pkg::t_func'(r_in.func);
    assign o_status.found    = !r_valid[r_idx] || !r_ref[r_idx];
    assign o_status.scan_end = (r_steps == '0);
    assign o_status.wb_hit   = r_valid[r_idx] && active[r_idx];
    assign o_status.wb_more  = wb_more;
    assign o_word            = r_out;

    // result word for the current command
    always_comb begin
        n_out = '0;
        n_out.last = 1'b1;
        unique case (tlb_pkg::t_func'(r_in.func))
            tlb_pkg::FN_LOOKUP: begin
                n_out.hit   = any_hit;
                n_out.frame = any_hit ? r_frame[hit_idx] : '0;
            end
            tlb_pkg::FN_INSERT: if (r_valid[r_idx]) begin
                n_out.wb_valid = 1'b1;
                n_out.wb_frame = r_frame[r_idx];
                n_out.wb_mod   = r_mod[r_idx];
                n_out.wb_ref   = r_ref[r_idx];
            end
            default: begin
                n_out.wb_valid = 1'b1;
                n_out.wb_frame = r_frame[r_idx];
                n_out.wb_mod   = r_mod[r_idx];
                n_out.wb_ref   = r_ref[r_idx];
                n_out.last     = !wb_more;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hand  <= '0;
            r_cfg   <= tlb_pkg::CNT_RESET;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (i_cmd.exec) begin
                unique case (tlb_pkg::t_func'(r_in.func))
                    tlb_pkg::FN_INSERT: begin
                        r_valid[r_idx] <= 1'b1;
                        r_hand <= next_idx;
                    end
                    tlb_pkg::FN_CLR_ENTRY: r_valid <= r_valid & ~(active & page_eq);
                    tlb_pkg::FN_CLR_ALL:   r_valid <= r_valid & ~active;
                    default: ;
                endcase
            end
        end
    end

    // entry payload, scan index and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_word;
            r_steps <= n_act;
            if (tlb_pkg::t_func'(i_word.func) == tlb_pkg::FN_INSERT)
                r_idx <= ({1'b0, r_hand} < (IW+1)'(n_act)) ? r_hand : '0;
            else
                r_idx <= '0;
        end
        if (i_cmd.scan) begin
            r_steps <= r_steps - 1'b1;
            if (tlb_pkg::t_func'(r_in.func) == tlb_pkg::FN_WRITEBACK)
                r_idx <= r_idx + 1'b1;
            else
                r_idx <= next_idx;
        end
        if (i_cmd.exec) begin
            unique case (tlb_pkg::t_func'(r_in.func))
                tlb_pkg::FN_LOOKUP: if (any_hit) begin
                    r_ref[hit_idx] <= 1'b1;
                    if (r_in.is_store) r_mod[hit_idx] <= 1'b1;
                end
                tlb_pkg::FN_INSERT: begin
                    r_page[r_idx]  <= in_page;
                    r_frame[r_idx] <= r_in.new_frame;
                    r_ref[r_idx]   <= r_in.new_ref;
                    r_mod[r_idx]   <= r_in.new_mod;
                end
                tlb_pkg::FN_CLR_REF: r_ref <= r_ref & ~active;
                default: ;
            endcase
        end
        if (i_cmd.emit) r_out <= n_out;
    end
endmodule

// File: design/tlb_clock_replacement.sv
// Top level of the fully associative TLB with clock replacement.
// Input channel (i_valid/o_stall) carries one command word; output channel
// (o_valid/i_stall) carries result words from a single output register.
// One command is in flight at a time: the block stalls input from the cycle
// after acceptance until the command finishes.
// Lookup: one result; the word is captured, then matched and updated.
// Clear entry / clear all / clear R: no result.
// Insert: victim search steps one entry per cycle from the clock hand over
// at most N active entries; one result. Write back: walks active entries
// one per cycle, while the receiver does not stall, up to the last valid
// one; one result per valid entry, last marked on the final one. A stalled
// receiver holds the output word; the walk waits for it. Reset clears all
// valid bits, the clock hand and sets entries_in_use to 16. Configuration
// (entries_in_use) is written with i_cfg_we; the user must write it only
// while idle, as the block does not enforce it.
module tlb_clock_replacement #(
    parameter int NUM_ENTRIES = tlb_pkg::NUM_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  tlb_pkg::t_in_word             i_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output tlb_pkg::t_out_word            o_word,
    input  logic                          i_cfg_we,
    input  logic [tlb_pkg::CNT_BITS-1:0]  i_cfg_data
);
    tlb_pkg::t_cmd    cmd;
    tlb_pkg::t_status status;

    tlb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_status(status), .o_cmd(cmd)
    );

    tlb_datapath #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
        .i_clk, .i_rst_n, .i_word, .i_cfg_we, .i_cfg_data,
        .i_cmd(cmd), .o_status(status), .o_word
    );
endmodule

// File: dv/tlb_checker.sv
// Checker for the clock-replacement TLB: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module tlb_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 o_stall,
    input  tlb_pkg::t_in_word    i_word,
    input  logic                 o_valid,
    input  logic                 i_stall,
    input  tlb_pkg::t_out_word   o_word,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import tlb_pkg::*;

    // shadow TLB state
    logic        sh_valid [16];
    logic [20:0] sh_page  [16];
    logic [20:0] sh_frame [16];
    logic        sh_ref   [16];
    logic        sh_mod   [16];
    int unsigned sh_hand;
    logic [4:0]  sh_in_use;

    t_out_word expected_words [$];

    assign o_pending = expected_words.size();

    function automatic int unsigned active_n();
        int unsigned n;
        n = sh_in_use;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        return n;
    endfunction

    function automatic t_out_word mk(logic h, logic [20:0] f, logic v, logic [20:0] wf,
                                     logic m, logic r, logic l);
        t_out_word w;
        w.hit = h; w.frame = f; w.wb_valid = v; w.wb_frame = wf;
        w.wb_mod = m; w.wb_ref = r; w.last = l;
        return w;
    endfunction

    // apply one command word to the shadow and queue the words it yields
    task automatic translate_word(t_in_word w);
        int unsigned n, i, start, pick, j, k;
        logic found;
        t_out_word r;
        n = active_n();
        case (t_func'(w.func))
            FN_LOOKUP: begin
                found = 0;
                for (i = 0; i < n && !found; i++) begin
                    if (sh_valid[i] && sh_page[i] == w.virt_page) begin
                        found = 1;
                        sh_ref[i] = 1;
                        if (w.is_store) sh_mod[i] = 1;
                        expected_words.push_back(mk(1, sh_frame[i], 0, 0, 0, 0, 1));
                    end
                end
                if (!found) expected_words.push_back(mk(0, 0, 0, 0, 0, 0, 1));
            end
            FN_INSERT: begin
                start = (sh_hand < n) ? sh_hand : 0;
                pick = start;
                found = 0;
                for (i = 0; i < n && !found; i++) begin
                    j = (start + i) % n;
                    if (!sh_valid[j] || !sh_ref[j]) begin
                        pick = j;
                        found = 1;
                    end
                end
                sh_hand = (pick + 1) % n;
                if (sh_valid[pick])
                    expected_words.push_back(mk(0, 0, 1, sh_frame[pick], sh_mod[pick],
                                                sh_ref[pick], 1));
                else
                    expected_words.push_back(mk(0, 0, 0, 0, 0, 0, 1));
                sh_valid[pick] = 1;
                sh_page[pick]  = w.virt_page;
                sh_frame[pick] = w.new_frame;
                sh_ref[pick]   = w.new_ref;
                sh_mod[pick]   = w.new_mod;
            end
            FN_CLR_ENTRY: for (i = 0; i < n; i++) if (sh_page[i] == w.virt_page) sh_valid[i] = 0;
            FN_CLR_ALL:   for (i = 0; i < n; i++) sh_valid[i] = 0;
            FN_CLR_REF:   for (i = 0; i < n; i++) sh_ref[i] = 0;
            FN_WRITEBACK: begin
                k = 0;
                for (i = 0; i < n; i++) begin
                    if (sh_valid[i]) begin
                        expected_words.push_back(mk(0, 0, 1, sh_frame[i], sh_mod[i],
                                                    sh_ref[i], 0));
                        k++;
                    end
                end
                if (k > 0) begin
                    r = expected_words.pop_back();
                    r.last = 1;
                    expected_words.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                sh_valid[i] = 0; sh_page[i] = 0; sh_frame[i] = 0;
                sh_ref[i] = 0; sh_mod[i] = 0;
            end
            sh_hand = 0;
            sh_in_use = CNT_RESET;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) sh_in_use = i_cfg_data;
            // result word check against the oldest expectation
            if (o_valid && !i_stall) begin
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word %h", o_word);
                end else begin
                    e = expected_words.pop_front();
                    if (e !== o_word) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp hit=%0d fr=%h wbv=%0d wbf=%h m=%0d r=%0d l=%0d got hit=%0d fr=%h wbv=%0d wbf=%h m=%0d r=%0d l=%0d",
                                e.hit, e.frame, e.wb_valid, e.wb_frame, e.wb_mod, e.wb_ref,
                                e.last, o_word.hit, o_word.frame, o_word.wb_valid,
                                o_word.wb_frame, o_word.wb_mod, o_word.wb_ref, o_word.last);
                    end
                end
            end
            if (i_valid && !o_stall) translate_word(i_word);
        end
    end
endmodule

// File: dv/tb_tlb_clock_replacement.sv
// Testbench top for the clock-replacement TLB: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_tlb_clock_replacement;
    import tlb_pkg::*;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_stall;
    t_in_word   i_word = '0;
    logic       o_valid;
    logic       i_stall = 0;
    t_out_word  o_word;
    logic       i_cfg_we = 0;
    logic [4:0] i_cfg_data = '0;
    int         fail_count;
    int         pending;
    int         stall_left;
    logic [20:0] page_pool [8];

    tlb_clock_replacement u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    tlb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_word(i_word), .o_valid(o_valid), .i_stall(i_stall), .o_word(o_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // receiver stall pattern: runs of random length, mostly short
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1;
            stall_left--;
        end else begin
            i_stall <= 0;
            stall_left = ($urandom_range(0, 9) < 4) ? gap_len() : 0;
        end
    end

    // send one command word, honoring random gaps and the stall handshake
    task automatic send_word(t_func f, logic [20:0] vp, logic st, logic [20:0] nf,
                             logic nr, logic nm);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1;
        i_word <= '{func: f, virt_page: vp, is_store: st, new_frame: nf,
                    new_ref: nr, new_mod: nm};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random();
        int unsigned sel;
        logic [20:0] vp;
        sel = $urandom_range(0, 99);
        vp = ($urandom_range(0, 3) == 0) ? 21'($urandom()) : page_pool[$urandom_range(0, 7)];
        if (sel < 40)      send_word(FN_LOOKUP, vp, 1'($urandom_range(0, 1)), 21'($urandom()),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else if (sel < 75) send_word(FN_INSERT, vp, 1'($urandom_range(0, 1)), 21'($urandom()),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else if (sel < 82) send_word(FN_CLR_ENTRY, vp, 0, 0, 0, 0);
        else if (sel < 85) send_word(FN_CLR_ALL, 21'($urandom()), 0, 0, 0, 0);
        else if (sel < 90) send_word(FN_CLR_REF, 21'($urandom()), 0, 0, 0, 0);
        else if (sel < 97) send_word(FN_WRITEBACK, 21'($urandom()), 0, 0, 0, 0);
        else send_word(t_func'($urandom_range(6, 7)), 21'($urandom()), 1, 21'($urandom()),
                       1, 1);
    endtask

    // drain, settle, then write the entry count
    task automatic set_in_use(logic [4:0] v);
        int guard;
        guard = 0;
        i_valid <= 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [4:0] settings [6];
        int guard;
        settings = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd16};
        for (int i = 0; i < 8; i++) page_pool[i] = 21'($urandom());
        page_pool[0] = 21'h1FFFFF;
        page_pool[1] = 21'h0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every command, unused codes
        send_word(FN_LOOKUP, 21'h0, 0, 0, 0, 0);
        send_word(FN_WRITEBACK, 0, 0, 0, 0, 0);
        send_word(FN_INSERT, 21'h1FFFFF, 0, 21'h1FFFFF, 1, 1);
        send_word(FN_INSERT, 21'h0, 0, 21'h0, 0, 0);
        send_word(FN_INSERT, 21'h0, 0, 21'h15555, 1, 0);
        send_word(FN_LOOKUP, 21'h0, 1, 0, 0, 0);
        send_word(FN_LOOKUP, 21'h1FFFFF, 1, 0, 0, 0);
        send_word(FN_WRITEBACK, 0, 0, 0, 0, 0);
        for (int i = 0; i < 15; i++)
            send_word(FN_INSERT, 21'(i + 5), 0, 21'($urandom()), 1, i[0]);
        send_word(FN_INSERT, 21'h77, 0, 21'h123, 0, 1);
        send_word(FN_CLR_REF, 0, 0, 0, 0, 0);
        send_word(FN_CLR_ENTRY, 21'h0, 0, 0, 0, 0);
        send_word(FN_RSVD6, 21'h1FFFFF, 1, 21'h1FFFFF, 1, 1);
        send_word(FN_RSVD7, 0, 0, 0, 0, 0);
        send_word(FN_WRITEBACK, 0, 0, 0, 0, 0);
        send_word(FN_CLR_ALL, 0, 0, 0, 0, 0);
        send_word(FN_WRITEBACK, 0, 0, 0, 0, 0);

        // random phases across several entry counts
        for (int p = 0; p < 6; p++) begin
            set_in_use(settings[p]);
            for (int k = 0; k < 56; k++) send_random();
        end

        i_valid <= 0;
        guard = 0;
        while (pending != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: tlb_clock_replacement.f
design/tlb_pkg.sv
design/tlb_ctrl.sv
design/tlb_datapath.sv
design/tlb_clock_replacement.sv
dv/tlb_checker.sv
dv/tb_tlb_clock_replacement.sv
